// ===== sv/ulmr_pkg.sv =====
package ulmr_pkg;

	localparam int SAMPLES_DEF = 5;
	localparam int TICKS_DEF   = 1000;

	localparam logic [31:0] TRIG_US   = 32'd10;
	localparam logic [15:0] MIN_WIDTH = 16'd116;
	localparam logic [15:0] MAX_WIDTH = 16'd14500;
	localparam logic [16:0] US_PER_CM = 17'd58;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_RISE = 2'd2,
		PH_FALL = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_INTERVAL = 3'd0,
		REG_SPACING  = 3'd1,
		REG_TIMEOUT  = 3'd2,
		REG_EMPTY    = 3'd3,
		REG_FULL     = 3'd4,
		REG_DELTA    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_COLLECT,
		FS_SORT,
		FS_DIV,
		FS_APPLY
	} fin_state_t;

	// controller -> datapath
	typedef struct packed {
		logic start;     // begin finish processing
		logic collect;   // collect one store entry
		logic sort_step; // one sort pass
		logic div_start; // load divider
		logic div_step;  // one division bit
		logic apply;     // commit result
	} fin_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic collect_last;
		logic sort_last;
		logic div_last;
	} fin_sts_t;

	typedef struct packed {
		logic [15:0] interval;
		logic [9:0]  spacing;
		logic [15:0] timeout;
		logic [15:0] empty;
		logic [15:0] full;
		logic [6:0]  delta;
	} cfg_t;

endpackage

// ===== sv/ulmr_if.sv =====
interface ulmr_in_if;
	logic valid;
	logic ready;
	logic echo_level;
	modport source (output valid, output echo_level, input ready);
	modport sink (input valid, input echo_level, output ready);
endinterface

interface ulmr_out_if;
	logic       valid;
	logic       ready;
	logic       trigger_level;
	logic [6:0] level_percent;
	logic [15:0] median_width_us;
	logic       level_error;
	logic       window_done;
	modport source (output valid, output trigger_level, output level_percent,
		output median_width_us, output level_error, output window_done, input ready);
	modport sink (input valid, input trigger_level, input level_percent,
		input median_width_us, input level_error, input window_done, output ready);
endinterface

// ===== sv/ulmr_ctrl.sv =====
module ulmr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fin_req,
	input  ulmr_pkg::fin_sts_t   sts,
	output ulmr_pkg::fin_cmd_t   cmd,
	output logic                 busy
);

	ulmr_pkg::fin_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ulmr_pkg::FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ulmr_pkg::FS_IDLE: begin
				if (fin_req) state_d = ulmr_pkg::FS_COLLECT;
			end
			ulmr_pkg::FS_COLLECT: begin
				if (sts.collect_last) state_d = ulmr_pkg::FS_SORT;
			end
			ulmr_pkg::FS_SORT: begin
				if (sts.sort_last) state_d = ulmr_pkg::FS_DIV;
			end
			ulmr_pkg::FS_DIV: begin
				if (sts.div_last) state_d = ulmr_pkg::FS_APPLY;
			end
			ulmr_pkg::FS_APPLY: state_d = ulmr_pkg::FS_IDLE;
			default: state_d = ulmr_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ulmr_pkg::FS_IDLE: begin
				busy = 1'b0;
				cmd.start = fin_req;
			end
			ulmr_pkg::FS_COLLECT: cmd.collect = 1'b1;
			ulmr_pkg::FS_SORT: begin
				cmd.sort_step = 1'b1;
				cmd.div_start = sts.sort_last;
			end
			ulmr_pkg::FS_DIV: cmd.div_step = 1'b1;
			ulmr_pkg::FS_APPLY: cmd.apply = 1'b1;
			default: busy = 1'b0;
		endcase
	end

endmodule

// ===== sv/ulmr_dp.sv =====
module ulmr_dp #(
	parameter int SAMPLES = ulmr_pkg::SAMPLES_DEF,
	parameter int TICKS   = ulmr_pkg::TICKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ulmr_pkg::cfg_t     cfg,
	input  logic               tick,
	input  logic               echo,
	input  ulmr_pkg::fin_cmd_t cmd,
	output ulmr_pkg::fin_sts_t sts,
	output logic               fin_req,
	output logic               trig,
	output logic [6:0]         pct,
	output logic [15:0]        median,
	output logic               err,
	output logic               done
);

	localparam int CW = $clog2(SAMPLES + 1);
	localparam int IW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
	localparam int DW = $clog2(TICKS + 1);

	ulmr_pkg::phase_t phase_q;
	logic [31:0] us_q, ms_q, start_q, rise_q, nwin_q, nsamp_q;
	logic [DW-1:0] div_q;
	logic win_q;
	logic [CW-1:0] cnt_q;
	logic [SAMPLES-1:0] sv_q;
	logic [15:0] sw_q [SAMPLES];
	logic [6:0] lastg_q, pct_q;
	logic hasg_q, err_q;
	logic [15:0] med_q;
	logic done_q;

	// per tick results
	logic fin_d, push, push_v, close_err;
	logic [15:0] push_w;
	logic [31:0] w32, el, dwin, dsmp;

	// finish: collect valid widths, odd-even sort, serial divide
	logic [15:0] tmp_q [SAMPLES];
	logic [CW-1:0] n_q, ci_q, pass_q;
	logic any_q, acc;
	logic [23:0] num_q;
	logic [16:0] den_q;
	logic [16:0] rem_q;
	logic [6:0] quo_q;
	logic [4:0] bit_q;
	logic [6:0] lvl;
	logic [15:0] mv;
	logic [16:0] rng;
	logic [15:0] dcl;
	logic [6:0] diff;
	logic [17:0] trial;

	assign el   = us_q - start_q;
	assign w32  = us_q - rise_q;
	assign dwin = ms_q - nwin_q;
	assign dsmp = ms_q - nsamp_q;

	always_comb begin
		fin_d = 1'b0; push = 1'b0; push_v = 1'b0; push_w = '0; close_err = 1'b0;
		if (phase_q == ulmr_pkg::PH_FALL && !echo) begin
			push = 1'b1;
			push_w = w32[15:0];
			push_v = (w32 >= {16'd0, ulmr_pkg::MIN_WIDTH}) &&
				(w32 <= {16'd0, ulmr_pkg::MAX_WIDTH});
		end else if ((phase_q == ulmr_pkg::PH_FALL || (phase_q == ulmr_pkg::PH_RISE && !echo))
			&& el >= {16'd0, cfg.timeout}) begin
			push = 1'b1;
		end
		if (push && ({1'b0, cnt_q} + 1'b1) >= (CW+1)'(SAMPLES)) begin
			if (phase_q == ulmr_pkg::PH_FALL && !echo) fin_d = 1'b1;
			else close_err = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ulmr_pkg::PH_IDLE;
			us_q <= '0; ms_q <= '0; div_q <= '0; start_q <= '0; rise_q <= '0;
			nwin_q <= '0; nsamp_q <= '0; win_q <= 1'b0; cnt_q <= '0; sv_q <= '0;
			err_q <= 1'b0; done_q <= 1'b0;
		end else begin
			if (tick) begin
				done_q <= close_err;
				unique case (phase_q)
					ulmr_pkg::PH_IDLE: begin
						if (!win_q) begin
							if (!dwin[31]) begin
								nwin_q <= ms_q + {16'd0, cfg.interval};
								win_q <= 1'b1;
								cnt_q <= '0;
								phase_q <= ulmr_pkg::PH_TRIG;
								start_q <= us_q;
							end
						end else if (cnt_q < CW'(SAMPLES) && !dsmp[31]) begin
							phase_q <= ulmr_pkg::PH_TRIG;
							start_q <= us_q;
						end
					end
					ulmr_pkg::PH_TRIG: begin
						if (el >= ulmr_pkg::TRIG_US) begin
							phase_q <= ulmr_pkg::PH_RISE;
							start_q <= us_q;
						end
					end
					ulmr_pkg::PH_RISE: begin
						if (echo) begin
							rise_q <= us_q;
							start_q <= us_q;
							phase_q <= ulmr_pkg::PH_FALL;
						end
					end
					ulmr_pkg::PH_FALL: ;
					default: ;
				endcase
				if (push) begin
					phase_q <= ulmr_pkg::PH_IDLE;
					if (cnt_q < CW'(SAMPLES)) begin
						sv_q[cnt_q[IW-1:0]] <= push_v;
						cnt_q <= cnt_q + 1'b1;
					end
					nsamp_q <= ms_q + {22'd0, cfg.spacing};
					if (close_err) begin
						err_q <= 1'b1;
						win_q <= 1'b0;
					end
				end
				us_q <= us_q + 1'b1;
				if (div_q + 1'b1 >= DW'(TICKS)) begin
					div_q <= '0;
					ms_q <= ms_q + 1'b1;
				end else begin
					div_q <= div_q + 1'b1;
				end
			end
			if (cmd.apply) begin
				win_q <= 1'b0;
				done_q <= 1'b1;
				if (acc) err_q <= 1'b0;
				else if (!any_q) err_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick && push && cnt_q < CW'(SAMPLES)) sw_q[cnt_q[IW-1:0]] <= push_w;
	end

	assign fin_req = tick && fin_d;

	assign mv  = tmp_q[IW'(n_q >> 1)];
	assign rng = {1'b0, cfg.empty} - {1'b0, cfg.full};
	assign dcl = (mv < cfg.full) ? cfg.full : ((mv > cfg.empty) ? cfg.empty : mv);
	assign lvl = (rng[16] || rng <= ulmr_pkg::US_PER_CM) ? 7'd0 :
		((quo_q > 7'd100) ? 7'd100 : quo_q);
	assign diff = (lvl > lastg_q) ? lvl - lastg_q : lastg_q - lvl;
	assign acc = any_q && !(hasg_q && diff > cfg.delta);
	assign trial = {rem_q, num_q[23]} - {1'b0, den_q};

	assign sts.collect_last = (ci_q == CW'(SAMPLES - 1));
	assign sts.sort_last    = (pass_q >= CW'(SAMPLES)) || (SAMPLES == 1);
	assign sts.div_last     = (bit_q == 5'd23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lastg_q <= '0; pct_q <= '0; hasg_q <= 1'b0; med_q <= '0;
			n_q <= '0; ci_q <= '0; pass_q <= '0; bit_q <= '0; any_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				n_q <= '0; ci_q <= '0; pass_q <= '0;
			end
			if (cmd.collect) begin
				ci_q <= ci_q + 1'b1;
				if (sv_q[ci_q[IW-1:0]] && ci_q < cnt_q) begin
					n_q <= n_q + 1'b1;
				end
			end
			if (cmd.sort_step) pass_q <= pass_q + 1'b1;
			if (cmd.div_start) begin
				bit_q <= '0;
				any_q <= (n_q != '0);
			end
			if (cmd.div_step) bit_q <= bit_q + 1'b1;
			if (cmd.apply) begin
				if (any_q) begin
					med_q <= mv;
					if (acc) begin
						pct_q <= lvl; lastg_q <= lvl; hasg_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.collect && sv_q[ci_q[IW-1:0]] && ci_q < cnt_q)
			tmp_q[n_q[IW-1:0]] <= sw_q[ci_q[IW-1:0]];
		if (cmd.sort_step) begin
			for (int k = 0; k + 1 < SAMPLES; k++) begin
				if ((k % 2) == (pass_q[0] ? 1 : 0) && (CW+1)'(k + 1) < {1'b0, n_q}
					&& tmp_q[k] > tmp_q[k+1]) begin
					tmp_q[k] <= tmp_q[k+1];
					tmp_q[k+1] <= tmp_q[k];
				end
			end
		end
		if (cmd.div_start) begin
			num_q <= 24'd200 * 24'(cfg.empty - dcl) + {7'd0, rng};
			den_q <= {rng[15:0], 1'b0};
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			num_q <= {num_q[22:0], 1'b0};
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[5:0], 1'b1};
			end else begin
				rem_q <= {rem_q[15:0], num_q[23]};
				quo_q <= {quo_q[5:0], 1'b0};
			end
		end
	end

	assign trig   = (phase_q == ulmr_pkg::PH_TRIG);
	assign pct    = pct_q;
	assign median = med_q;
	assign err    = err_q;
	assign done   = done_q;

endmodule

// ===== sv/ultrasonic_level_median_ranger.sv =====
// channel  dir  payload
// in       in   echo_level
// out      out  trigger_level, level_percent, median_width_us, level_error, window_done
// one result per tick; the next tick is accepted only after out takes the result
// a tick that closes a window with samples runs collect, sort and a 24 step serial
// divider before the next tick is accepted
// arst_n clears all control state; the output register holds while out is stalled
module ultrasonic_level_median_ranger #(
	parameter int SAMPLES_PER_WINDOW = ulmr_pkg::SAMPLES_DEF,
	parameter int TICKS_PER_MS       = ulmr_pkg::TICKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ulmr_in_if.sink     in_ch,
	ulmr_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ulmr_pkg::cfg_t cfg_q;
	ulmr_pkg::fin_cmd_t cmd;
	ulmr_pkg::fin_sts_t sts;
	logic busy, fin_req, tick, pend_q, trig;
	logic [6:0] pct;
	logic [15:0] med;
	logic err, done;
	logic fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.interval <= 16'd2000; cfg_q.spacing <= 10'd60; cfg_q.timeout <= 16'd30000;
			cfg_q.empty <= 16'd11600; cfg_q.full <= 16'd1160; cfg_q.delta <= 7'd10;
		end else if (cfg_we) begin
			unique case (ulmr_pkg::reg_idx_t'(cfg_index))
				ulmr_pkg::REG_INTERVAL: cfg_q.interval <= cfg_data;
				ulmr_pkg::REG_SPACING:  cfg_q.spacing <= cfg_data[9:0];
				ulmr_pkg::REG_TIMEOUT:  cfg_q.timeout <= cfg_data;
				ulmr_pkg::REG_EMPTY:    cfg_q.empty <= cfg_data;
				ulmr_pkg::REG_FULL:     cfg_q.full <= cfg_data;
				ulmr_pkg::REG_DELTA:    cfg_q.delta <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// accept a tick only when no result waits and no finish runs
	assign in_ch.ready = !pend_q && !busy && !fin_d;
	assign tick = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0; fin_d <= 1'b0;
		end else begin
			fin_d <= fin_req;
			if (tick && !fin_req) pend_q <= 1'b1;
			else if (cmd.apply) pend_q <= 1'b1;
			else if (out_ch.ready) pend_q <= 1'b0;
		end
	end

	ulmr_ctrl u_ctrl (
		.clk, .arst_n, .fin_req, .sts, .cmd, .busy
	);

	ulmr_dp #(.SAMPLES(SAMPLES_PER_WINDOW), .TICKS(TICKS_PER_MS)) u_dp (
		.clk, .arst_n, .cfg(cfg_q), .tick, .echo(in_ch.echo_level), .cmd, .sts,
		.fin_req, .trig, .pct, .median(med), .err, .done
	);

	assign out_ch.valid           = pend_q;
	assign out_ch.trigger_level   = trig;
	assign out_ch.level_percent   = pct;
	assign out_ch.median_width_us = med;
	assign out_ch.level_error     = err;
	assign out_ch.window_done     = done;

endmodule

// ===== sv/ulmr_checker.sv =====
module ulmr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [6:0] level_percent,
	input logic window_done
);

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !(in_valid && in_ready))
		else $error("tick taken while result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_percent <= 7'd100)
		else $error("percent out of range");

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && window_done |=> !(out_valid && window_done && $past(out_ready)))
		else $error("done repeated");

endmodule

bind ultrasonic_level_median_ranger ulmr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.level_percent(out_ch.level_percent), .window_done(out_ch.window_done)
);
